// ===== hw/rtl/des_pkg.sv =====
package des_pkg;

   localparam int MAX_SAMPLES  = 1024;
   localparam int SAMPLE_BITS  = 16;
   localparam int ADDR_BITS    = $clog2(MAX_SAMPLES);
   localparam int CNT_BITS     = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS     = 26;
   localparam int S2_BITS      = 42;
   localparam int RSUM_BITS    = 43;
   localparam int T1_BITS      = 53;
   localparam int T2_BITS      = 52;
   localparam int DEN_BITS     = 22;
   localparam int DIV_DVD_BITS = 96;
   localparam int DIV_DSR_BITS = 43;
   localparam int DIV_CNT_BITS = $clog2(DIV_DVD_BITS);
   localparam int SQRT_BITS    = 64;
   localparam int ROOT_BITS    = 32;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_value;
      logic                   is_last;
   } req_type;

   typedef struct packed {
      logic [15:0] min_value;
      logic [15:0] max_value;
      logic [15:0] range_value;
      logic [15:0] mode_value;
      logic [16:0] median_x2;
      logic [25:0] sum_total;
      logic [31:0] mean_q16;
      logic [31:0] harmonic_q16;
      logic [31:0] stddev_q16;
      logic [15:0] iqr_value;
      logic [10:0] sample_count;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic                    start;
      logic [DIV_DVD_BITS-1:0] dividend;
      logic [DIV_DSR_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic [DIV_DVD_BITS-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [SQRT_BITS-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] root;
   } sqrt_rsp_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SORT_START,
      ST_SORT_FIRST,
      ST_SORT_RUN,
      ST_SORT_TAIL,
      ST_STAT_READ,
      ST_STAT_DATA,
      ST_STAT_ACC,
      ST_STAT_RECIP,
      ST_MEAN,
      ST_MEAN_WAIT,
      ST_HARM,
      ST_HARM_WAIT,
      ST_VAR_MUL1,
      ST_VAR_MUL2,
      ST_VAR_MUL3,
      ST_VAR_SUB,
      ST_VAR_WAIT,
      ST_SQRT_WAIT,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/descriptive_statistics_engine_top.sv =====
// Descriptive statistics over a set of unsigned samples.
//
// Input channel (req_valid / req_stall / req_data): one sample per word. Words
// load at one per cycle while the set is open; the word with is_last closes
// the set. Samples beyond the store depth are dropped, but their is_last
// still closes the set.
// After the closing word req_stall stays high while the engine works:
//   sort   : in-place bubble sort over the sample memory, one compare per
//            cycle (one read/one write port).
//   stats  : one pass over the sorted data, with a reciprocal on the shared
//            divider for each nonzero sample.
//   finish : up to three more divisions and a square root.
// Result channel (rsp_valid / rsp_stall / rsp_data): one word per set, held
// in an output register. A stalled result holds; the next set can load
// behind it, and a new result waits until the register frees up.
// Reset (synchronous, active high) empties the set and drops any pending
// result; the sample memory needs no clearing pass.
module descriptive_statistics_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  des_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output des_pkg::rsp_type rsp_data
);
   import des_pkg::*;

   state_type state_ff, state_in;

   // set accumulators
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic                   zero_ff, zero_in;

   // sort control
   logic [CNT_BITS-1:0]    len_ff, len_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [SAMPLE_BITS-1:0] carry_ff, carry_in;

   // stats pass
   logic [CNT_BITS-1:0]      i_ff, i_in;
   logic [SAMPLE_BITS-1:0]   x_ff, x_in;
   logic [2*SAMPLE_BITS-1:0] prod_ff, prod_in;
   logic [S2_BITS-1:0]       s2_ff, s2_in;
   logic [RSUM_BITS-1:0]     rsum_ff, rsum_in;
   logic [SAMPLE_BITS-1:0]   prev_ff, prev_in;
   logic [CNT_BITS-1:0]      run_ff, run_in;
   logic [CNT_BITS-1:0]      best_ff, best_in;
   logic [SAMPLE_BITS-1:0]   mode_ff, mode_in;
   logic [SAMPLE_BITS-1:0]   med_a_ff, med_a_in, med_b_ff, med_b_in;
   logic [SAMPLE_BITS-1:0]   q1_a_ff, q1_a_in, q1_b_ff, q1_b_in;
   logic [SAMPLE_BITS-1:0]   q3_a_ff, q3_a_in, q3_b_ff, q3_b_in;

   // final results
   logic [31:0]          mean_ff, mean_in;
   logic [31:0]          harm_ff, harm_in;
   logic [31:0]          sd_ff, sd_in;
   logic [T1_BITS-1:0]   t1_ff, t1_in;
   logic [T2_BITS-1:0]   t2_ff, t2_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // memory port
   logic                   ram_we;
   logic [ADDR_BITS-1:0]   ram_waddr, ram_raddr;
   logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   // order-statistic positions
   logic [CNT_BITS-1:0] half, quarter, three_q;
   logic [CNT_BITS+1:0] three_n;
   logic [CNT_BITS-1:0] pos_ma, pos_mb, pos_q1a, pos_q1b, pos_q3a, pos_q3b;

   logic                   req_accept;
   logic                   last_idx;
   logic [CNT_BITS-1:0]    run_new;
   logic [SAMPLE_BITS:0]   q1_sum, q3_sum;
   logic [SAMPLE_BITS-1:0] q1_val, q3_val;
   logic [T1_BITS-1:0]     dvar;

   des_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(MAX_SAMPLES)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   des_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   des_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .req  (sqrt_req),
      .rsp  (sqrt_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff   <= len_in;
      idx_ff   <= idx_in;
      carry_ff <= carry_in;
      i_ff     <= i_in;
      x_ff     <= x_in;
      prod_ff  <= prod_in;
      s2_ff    <= s2_in;
      rsum_ff  <= rsum_in;
      prev_ff  <= prev_in;
      run_ff   <= run_in;
      best_ff  <= best_in;
      mode_ff  <= mode_in;
      med_a_ff <= med_a_in;
      med_b_ff <= med_b_in;
      q1_a_ff  <= q1_a_in;
      q1_b_ff  <= q1_b_in;
      q3_a_ff  <= q3_a_in;
      q3_b_ff  <= q3_b_in;
      mean_ff  <= mean_in;
      harm_ff  <= harm_in;
      sd_ff    <= sd_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      den_ff   <= den_in;
      rsp_ff   <= rsp_in;
   end

   // Median and quartile positions; for an odd count both members of a pair
   // point at the same sample so the pair sum covers both cases.
   always_comb begin
      half    = count_ff >> 1;
      quarter = count_ff >> 2;
      three_n = {2'b00, count_ff} + {1'b0, count_ff, 1'b0};
      three_q = three_n[CNT_BITS+1:2];
      if (count_ff[0]) begin
         pos_ma  = half;
         pos_mb  = half;
         pos_q1a = quarter;
         pos_q1b = quarter;
         pos_q3a = three_q;
         pos_q3b = three_q;
      end else begin
         pos_ma  = half - CNT_BITS'(1);
         pos_mb  = half;
         // clamp the lower quartile index for a two-sample set
         pos_q1a = (quarter == '0) ? '0 : quarter - CNT_BITS'(1);
         pos_q1b = quarter;
         pos_q3a = three_q - CNT_BITS'(1);
         pos_q3b = three_q;
      end
   end

   assign req_accept = req_valid & ~req_stall;
   assign req_stall  = (state_ff != ST_LOAD);
   assign last_idx   = (i_ff == count_ff - CNT_BITS'(1));
   assign q1_sum     = {1'b0, q1_a_ff} + {1'b0, q1_b_ff};
   assign q3_sum     = {1'b0, q3_a_ff} + {1'b0, q3_b_ff};
   assign q1_val     = q1_sum[SAMPLE_BITS:1];
   assign q3_val     = q3_sum[SAMPLE_BITS:1];
   assign dvar       = t1_ff - T1_BITS'(t2_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      zero_in   = zero_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      carry_in  = carry_ff;
      i_in      = i_ff;
      x_in      = x_ff;
      prod_in   = prod_ff;
      s2_in     = s2_ff;
      rsum_in   = rsum_ff;
      prev_in   = prev_ff;
      run_in    = run_ff;
      best_in   = best_ff;
      mode_in   = mode_ff;
      med_a_in  = med_a_ff;
      med_b_in  = med_b_ff;
      q1_a_in   = q1_a_ff;
      q1_b_in   = q1_b_ff;
      q3_a_in   = q3_a_ff;
      q3_b_in   = q3_b_ff;
      mean_in   = mean_ff;
      harm_in   = harm_ff;
      sd_in     = sd_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      den_in    = den_ff;
      rsp_in    = rsp_ff;
      // drop the result once the receiver takes it
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      div_req   = '0;
      sqrt_req  = '0;
      run_new   = '0;

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (count_ff < CNT_BITS'(MAX_SAMPLES)) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[ADDR_BITS-1:0];
                  ram_wdata = req_data.sample_value;
                  count_in  = count_ff + CNT_BITS'(1);
                  sum_in    = sum_ff + SUM_BITS'(req_data.sample_value);
                  if (req_data.sample_value < min_ff) min_in = req_data.sample_value;
                  if (req_data.sample_value > max_ff) max_in = req_data.sample_value;
                  if (req_data.sample_value == '0) zero_in = 1'b1;
               end
               if (req_data.is_last) begin
                  len_in   = count_in;
                  i_in     = '0;
                  state_in = (count_in < CNT_BITS'(2)) ? ST_STAT_READ : ST_SORT_START;
               end
            end
         end
         ST_SORT_START: begin
            ram_raddr = '0;
            state_in  = ST_SORT_FIRST;
         end
         ST_SORT_FIRST: begin
            carry_in  = ram_rdata;
            ram_raddr = ADDR_BITS'(1);
            idx_in    = CNT_BITS'(2);
            state_in  = ST_SORT_RUN;
         end
         ST_SORT_RUN: begin
            // write back the smaller one, carry the larger one up the pass
            ram_we    = 1'b1;
            ram_waddr = ADDR_BITS'(idx_ff - CNT_BITS'(2));
            if (ram_rdata < carry_ff) begin
               ram_wdata = ram_rdata;
            end else begin
               ram_wdata = carry_ff;
               carry_in  = ram_rdata;
            end
            if (idx_ff == len_ff) begin
               state_in = ST_SORT_TAIL;
            end else begin
               ram_raddr = idx_ff[ADDR_BITS-1:0];
               idx_in    = idx_ff + CNT_BITS'(1);
            end
         end
         ST_SORT_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_BITS'(len_ff - CNT_BITS'(1));
            ram_wdata = carry_ff;
            len_in    = len_ff - CNT_BITS'(1);
            if (len_in < CNT_BITS'(2)) begin
               i_in     = '0;
               state_in = ST_STAT_READ;
            end else begin
               state_in = ST_SORT_START;
            end
         end
         ST_STAT_READ: begin
            ram_raddr = i_ff[ADDR_BITS-1:0];
            state_in  = ST_STAT_DATA;
         end
         ST_STAT_DATA: begin
            x_in    = ram_rdata;
            prod_in = {{SAMPLE_BITS{1'b0}}, ram_rdata} * {{SAMPLE_BITS{1'b0}}, ram_rdata};
            prev_in = ram_rdata;
            // longest run in sorted order; ties keep the earlier, smaller value
            if (i_ff == '0) begin
               mode_in = ram_rdata;
               best_in = CNT_BITS'(1);
               run_in  = CNT_BITS'(1);
            end else begin
               run_new = (ram_rdata == prev_ff) ? run_ff + CNT_BITS'(1) : CNT_BITS'(1);
               run_in  = run_new;
               if (run_new > best_ff) begin
                  best_in = run_new;
                  mode_in = ram_rdata;
               end
            end
            if (i_ff == pos_ma)  med_a_in = ram_rdata;
            if (i_ff == pos_mb)  med_b_in = ram_rdata;
            if (i_ff == pos_q1a) q1_a_in  = ram_rdata;
            if (i_ff == pos_q1b) q1_b_in  = ram_rdata;
            if (i_ff == pos_q3a) q3_a_in  = ram_rdata;
            if (i_ff == pos_q3b) q3_b_in  = ram_rdata;
            if (i_ff == '0) begin
               s2_in   = '0;
               rsum_in = '0;
            end
            state_in = ST_STAT_ACC;
         end
         ST_STAT_ACC: begin
            s2_in = s2_ff + S2_BITS'(prod_ff);
            if (x_ff != '0) begin
               // reciprocal with 32 fraction bits
               div_req.start    = 1'b1;
               div_req.dividend = DIV_DVD_BITS'(1) << 32;
               div_req.divisor  = DIV_DSR_BITS'(x_ff);
               state_in         = ST_STAT_RECIP;
            end else if (last_idx) begin
               state_in = ST_MEAN;
            end else begin
               i_in     = i_ff + CNT_BITS'(1);
               state_in = ST_STAT_READ;
            end
         end
         ST_STAT_RECIP: begin
            if (div_rsp.done) begin
               rsum_in = rsum_ff + RSUM_BITS'(div_rsp.quotient[32:0]);
               if (last_idx) begin
                  state_in = ST_MEAN;
               end else begin
                  i_in     = i_ff + CNT_BITS'(1);
                  state_in = ST_STAT_READ;
               end
            end
         end
         ST_MEAN: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_DVD_BITS'({sum_ff, 16'h0000});
            div_req.divisor  = DIV_DSR_BITS'(count_ff);
            state_in         = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient[31:0];
               state_in = ST_HARM;
            end
         end
         ST_HARM: begin
            if (zero_ff || rsum_ff == '0) begin
               harm_in  = '0;
               state_in = ST_VAR_MUL1;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_DVD_BITS'({count_ff, 48'h0});
               div_req.divisor  = rsum_ff;
               state_in         = ST_HARM_WAIT;
            end
         end
         ST_HARM_WAIT: begin
            if (div_rsp.done) begin
               // saturate to the Q16.16 range
               harm_in  = (|div_rsp.quotient[DIV_DVD_BITS-1:32]) ? '1
                                                                 : div_rsp.quotient[31:0];
               state_in = ST_VAR_MUL1;
            end
         end
         ST_VAR_MUL1: begin
            if (count_ff < CNT_BITS'(2)) begin
               sd_in    = '0;
               state_in = ST_FINISH;
            end else begin
               t1_in    = T1_BITS'(count_ff) * T1_BITS'(s2_ff);
               state_in = ST_VAR_MUL2;
            end
         end
         ST_VAR_MUL2: begin
            t2_in    = T2_BITS'(sum_ff) * T2_BITS'(sum_ff);
            state_in = ST_VAR_MUL3;
         end
         ST_VAR_MUL3: begin
            den_in   = DEN_BITS'(count_ff) * DEN_BITS'(count_ff - CNT_BITS'(1));
            state_in = ST_VAR_SUB;
         end
         ST_VAR_SUB: begin
            // variance in Q32.32: exact integer difference scaled before dividing
            div_req.start    = 1'b1;
            div_req.dividend = DIV_DVD_BITS'({dvar, 32'h0});
            div_req.divisor  = DIV_DSR_BITS'(den_ff);
            state_in         = ST_VAR_WAIT;
         end
         ST_VAR_WAIT: begin
            if (div_rsp.done) begin
               sqrt_req.start = 1'b1;
               sqrt_req.value = div_rsp.quotient[SQRT_BITS-1:0];
               state_in       = ST_SQRT_WAIT;
            end
         end
         ST_SQRT_WAIT: begin
            if (sqrt_rsp.done) begin
               sd_in    = sqrt_rsp.root;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.min_value    = min_ff;
               rsp_in.max_value    = max_ff;
               rsp_in.range_value  = max_ff - min_ff;
               rsp_in.mode_value   = mode_ff;
               rsp_in.median_x2    = {1'b0, med_a_ff} + {1'b0, med_b_ff};
               rsp_in.sum_total    = sum_ff;
               rsp_in.mean_q16     = mean_ff;
               rsp_in.harmonic_q16 = harm_ff;
               rsp_in.stddev_q16   = sd_ff;
               rsp_in.iqr_value    = q3_val - q1_val;
               rsp_in.sample_count = count_ff;
               rsp_in.status       = {zero_ff, (count_ff == CNT_BITS'(1))};
               rsp_valid_in        = 1'b1;
               count_in            = '0;
               sum_in              = '0;
               min_in              = '1;
               max_in              = '0;
               zero_in             = 1'b0;
               state_in            = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/des_ram.sv =====
module des_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/des_div.sv =====
module des_div (
   input  logic                 clock,
   input  logic                 reset,
   input  des_pkg::div_req_type req,
   output des_pkg::div_rsp_type rsp
);
   import des_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_DVD_BITS-1:0] dvd_ff, dvd_in;
   logic [DIV_DSR_BITS-1:0] dsr_ff, dsr_in;
   logic [DIV_DSR_BITS-1:0] rem_ff, rem_in;
   logic [DIV_DSR_BITS:0]   rem_sh;
   logic [DIV_DSR_BITS:0]   diff;
   logic                    ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      rem_sh  = {rem_ff, dvd_ff[DIV_DVD_BITS-1]};
      diff    = rem_sh - {1'b0, dsr_ff};
      ge      = (rem_sh >= {1'b0, dsr_ff});
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DSR_BITS-1:0] : rem_sh[DIV_DSR_BITS-1:0];
         dvd_in = {dvd_ff[DIV_DVD_BITS-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(DIV_DVD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;

endmodule

// ===== hw/rtl/des_sqrt.sv =====
module des_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  des_pkg::sqrt_req_type req,
   output des_pkg::sqrt_rsp_type rsp
);
   import des_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SQRT_BITS-1:0] v_ff, v_in;
   logic [SQRT_BITS-1:0] r_ff, r_in;
   logic [SQRT_BITS-1:0] bit_ff, bit_in;
   logic [SQRT_BITS-1:0] trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   // one result bit per cycle, trial bit walks down two places per step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      trial   = r_ff + bit_ff;
      if (req.start) begin
         busy_in = 1'b1;
         v_in    = req.value;
         r_in    = '0;
         bit_in  = SQRT_BITS'(1) << (SQRT_BITS - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = r_ff[ROOT_BITS-1:0];

endmodule
